// ===== hw/rtl/mrme_pkg.sv =====
// Shared types, codes and defaults for the memory region map engine.
package mrme_pkg;

	localparam int MAX_REGIONS_DEF = 256;
	localparam int PAGE_BYTES_DEF  = 4096;

	localparam logic [63:0] LOW_BOUND  = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ADDR32_MAX = 64'h0000_0000_FFFF_FFFF;

	localparam logic [2:0] CMD_APPEND   = 3'd0;
	localparam logic [2:0] CMD_SANITIZE = 3'd1;
	localparam logic [2:0] CMD_CLAIM    = 3'd2;
	localparam logic [2:0] CMD_REQUEST  = 3'd3;
	localparam logic [2:0] CMD_READ     = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NOFIT   = 2'd3;

	localparam logic REG_USABLE      = 1'b0;
	localparam logic REG_RECLAIMABLE = 1'b1;

	localparam int IN_BITS  = 200;
	localparam int OUT_BITS = 176;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] size;
		logic [63:0] start;
	} entry_t;

endpackage

// ===== hw/rtl/mrme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/memory_region_map_engine.sv =====
// Memory region map engine: region table sequencer around one table RAM.
// Sanitize runs the overlap and merge passes, then compaction, alignment and
// the sort over the n entries, each entry read through the single read port
// of the table RAM. One command at a time.
// Reset clears the entry count and state; the usable and reclaimable kind
// registers reset to 1 and 6, and table contents stay undefined.
module memory_region_map_engine #(
	parameter int MAX_REGIONS = mrme_pkg::MAX_REGIONS_DEF,
	parameter int PAGE_BYTES  = mrme_pkg::PAGE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command, base_addr, length_bytes, region_kind, page_count, entry_index
	input  logic [mrme_pkg::IN_BITS-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, granted_addr, entry_base, entry_length, entry_kind, entry_total
	output logic [mrme_pkg::OUT_BITS-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int AW = $clog2(MAX_REGIONS);
	localparam int CW = AW + 1;
	localparam int PB_LOG = $clog2(PAGE_BYTES);
	localparam logic [CW-1:0] LIM_C = CW'(MAX_REGIONS - 1);
	localparam logic [CW:0] LIM_W = (CW + 1)'(MAX_REGIONS - 1);
	localparam logic [63:0] PMASK = 64'(PAGE_BYTES - 1);
	localparam logic [63:0] PSIZE = 64'(PAGE_BYTES);

	localparam logic [5:0] S_IDLE     = 6'd0;
	localparam logic [5:0] S_DISP     = 6'd1;
	localparam logic [5:0] S_A_WR     = 6'd2;
	localparam logic [5:0] S_RD_RD    = 6'd3;
	localparam logic [5:0] S_RD_LD    = 6'd4;
	localparam logic [5:0] S_P1_I_RD  = 6'd5;
	localparam logic [5:0] S_P1_I_LD  = 6'd6;
	localparam logic [5:0] S_P1_J_RD  = 6'd7;
	localparam logic [5:0] S_P1_J_LD  = 6'd8;
	localparam logic [5:0] S_P1_J_EX  = 6'd9;
	localparam logic [5:0] S_P1_SPLIT = 6'd10;
	localparam logic [5:0] S_P1_I_WR  = 6'd11;
	localparam logic [5:0] S_P1_ABORT = 6'd12;
	localparam logic [5:0] S_P2_I_RD  = 6'd13;
	localparam logic [5:0] S_P2_I_LD  = 6'd14;
	localparam logic [5:0] S_P2_J_RD  = 6'd15;
	localparam logic [5:0] S_P2_J_LD  = 6'd16;
	localparam logic [5:0] S_P2_J_EX  = 6'd17;
	localparam logic [5:0] S_P2_I_WR  = 6'd18;
	localparam logic [5:0] S_CP_RD    = 6'd19;
	localparam logic [5:0] S_CP_LD    = 6'd20;
	localparam logic [5:0] S_AL_RD    = 6'd21;
	localparam logic [5:0] S_AL_LD    = 6'd22;
	localparam logic [5:0] S_AL_EX    = 6'd23;
	localparam logic [5:0] S_AL_WR    = 6'd24;
	localparam logic [5:0] S_SO_I     = 6'd25;
	localparam logic [5:0] S_SO_J_RD  = 6'd26;
	localparam logic [5:0] S_SO_J_LD  = 6'd27;
	localparam logic [5:0] S_SO_SW1   = 6'd28;
	localparam logic [5:0] S_SO_SW2   = 6'd29;
	localparam logic [5:0] S_CL_START = 6'd30;
	localparam logic [5:0] S_CL_RD    = 6'd31;
	localparam logic [5:0] S_CL_LD    = 6'd32;
	localparam logic [5:0] S_CL_EX    = 6'd33;
	localparam logic [5:0] S_CL_APP   = 6'd34;
	localparam logic [5:0] S_RQ_RD    = 6'd35;
	localparam logic [5:0] S_RQ_LD    = 6'd36;
	localparam logic [5:0] S_FIN      = 6'd37;

	logic [5:0] state_q;
	logic [3:0] usable_q, recl_q;
	logic [CW-1:0] cnt_q, i_q, j_q, k_q, least_q;
	mrme_pkg::entry_t ie_q, je_q, le_q, rde_q;
	logic [63:0] iend_q, jend_q;
	logic [2:0] cmd_q;
	logic [63:0] base_q, len_q, size_q, cl_base_q, cl_len_q, cl_end_q;
	logic [3:0] kind_q;
	logic [51:0] pages_q;
	logic [7:0] idx_q;
	logic [1:0] status_q;
	logic [31:0] granted_q;
	logic req_q;
	logic m_valid_q;
	logic [mrme_pkg::OUT_BITS-1:0] m_data_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	mrme_pkg::entry_t mem_wdata, mem_rdata;
	logic [31:0] idx32, tot32;
	logic p1_cont, p1_part, p2_merge, al_hit;
	logic [63:0] al_rem;

	mrme_ram #(
		.WIDTH($bits(mrme_pkg::entry_t)),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == mrme_pkg::REG_RECLAIMABLE) ? {28'd0, recl_q} :
	                  {28'd0, usable_q};

	assign idx32 = 32'(idx_q);
	assign tot32 = 32'(cnt_q);
	assign p1_cont = (je_q.start >= ie_q.start) && (jend_q <= iend_q);
	assign p1_part = (je_q.start >= ie_q.start) && (je_q.start < iend_q);
	assign p2_merge = (jend_q == ie_q.start) && (je_q.kind == ie_q.kind);
	assign al_hit = (mem_rdata.kind == usable_q) || (mem_rdata.kind == recl_q);
	assign al_rem = je_q.start & PMASK;

	always_comb begin
		unique case (state_q)
			S_P1_J_RD, S_P2_J_RD, S_SO_J_RD: mem_raddr = j_q[AW-1:0];
			S_RQ_RD:                         mem_raddr = k_q[AW-1:0];
			S_RD_RD:                         mem_raddr = idx32[AW-1:0];
			default:                         mem_raddr = i_q[AW-1:0];
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = ie_q;
		unique case (state_q)
			S_A_WR: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = '{kind: kind_q, size: len_q, start: base_q};
			end
			S_P1_J_EX: begin
				mem_waddr = j_q[AW-1:0];
				if (p1_cont) begin
					mem_we = (je_q.kind <= ie_q.kind);
					mem_wdata = '{kind: je_q.kind, size: 64'd0, start: je_q.start};
				end else begin
					mem_we = p1_part && (je_q.kind < ie_q.kind);
					mem_wdata = '{kind: je_q.kind, size: je_q.size - (iend_q - je_q.start),
						start: iend_q};
				end
			end
			S_P1_SPLIT: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = '{kind: ie_q.kind, size: iend_q - jend_q, start: jend_q};
			end
			S_P1_I_WR, S_P1_ABORT, S_P2_I_WR: begin
				mem_we = 1'b1;
			end
			S_P2_J_EX: begin
				mem_we = p2_merge;
				mem_waddr = j_q[AW-1:0];
				mem_wdata = '{kind: je_q.kind, size: je_q.size + ie_q.size, start: je_q.start};
			end
			S_CP_LD: begin
				mem_we = (mem_rdata.size != 64'd0) && (j_q != i_q);
				mem_waddr = j_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			S_AL_WR: begin
				mem_we = 1'b1;
				mem_wdata = '{kind: je_q.kind, size: je_q.size & ~PMASK, start: je_q.start};
			end
			S_SO_SW1: begin
				mem_we = 1'b1;
				mem_wdata = le_q;
			end
			S_SO_SW2: begin
				mem_we = 1'b1;
				mem_waddr = least_q[AW-1:0];
				mem_wdata = ie_q;
			end
			S_CL_APP: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = '{kind: kind_q, size: cl_len_q, start: cl_base_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			usable_q <= 4'd1;
			recl_q <= 4'd6;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			least_q <= '0;
			ie_q <= '0;
			je_q <= '0;
			le_q <= '0;
			rde_q <= '0;
			iend_q <= '0;
			jend_q <= '0;
			cmd_q <= '0;
			base_q <= '0;
			len_q <= '0;
			size_q <= '0;
			cl_base_q <= '0;
			cl_len_q <= '0;
			cl_end_q <= '0;
			kind_q <= '0;
			pages_q <= '0;
			idx_q <= '0;
			status_q <= mrme_pkg::ST_OK;
			granted_q <= '0;
			req_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == mrme_pkg::REG_RECLAIMABLE) begin
					recl_q <= pwdata[3:0];
				end else begin
					usable_q <= pwdata[3:0];
				end
			end
			if (m_valid_q && m_tready && (state_q != S_FIN)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tdata[2:0];
						base_q <= s_tdata[66:3];
						len_q <= s_tdata[130:67];
						kind_q <= s_tdata[134:131];
						pages_q <= s_tdata[186:135];
						idx_q <= s_tdata[194:187];
						status_q <= mrme_pkg::ST_OK;
						granted_q <= '0;
						rde_q <= '0;
						req_q <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					i_q <= '0;
					k_q <= '0;
					cl_base_q <= base_q;
					cl_len_q <= len_q;
					size_q <= {12'd0, pages_q} << PB_LOG;
					unique case (cmd_q)
						mrme_pkg::CMD_APPEND: begin
							if (cnt_q >= LIM_C) begin
								status_q <= mrme_pkg::ST_FULL;
								state_q <= S_FIN;
							end else if (base_q < mrme_pkg::LOW_BOUND) begin
								if (len_q <= mrme_pkg::LOW_BOUND) begin
									state_q <= S_FIN;
								end else begin
									len_q <= len_q - (mrme_pkg::LOW_BOUND - base_q);
									base_q <= mrme_pkg::LOW_BOUND;
									state_q <= S_A_WR;
								end
							end else begin
								state_q <= S_A_WR;
							end
						end
						mrme_pkg::CMD_SANITIZE: state_q <= S_P1_I_RD;
						mrme_pkg::CMD_CLAIM:    state_q <= S_CL_START;
						mrme_pkg::CMD_REQUEST: begin
							req_q <= 1'b1;
							status_q <= mrme_pkg::ST_NOFIT;
							state_q <= S_RQ_RD;
						end
						mrme_pkg::CMD_READ: begin
							state_q <= (idx32 < tot32) ? S_RD_RD : S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_A_WR: begin
					cnt_q <= cnt_q + CW'(1);
					state_q <= S_FIN;
				end
				S_RD_RD: state_q <= S_RD_LD;
				S_RD_LD: begin
					rde_q <= mem_rdata;
					state_q <= S_FIN;
				end
				S_P1_I_RD: begin
					if (i_q >= cnt_q) begin
						i_q <= '0;
						state_q <= S_P2_I_RD;
					end else begin
						state_q <= S_P1_I_LD;
					end
				end
				S_P1_I_LD: begin
					ie_q <= mem_rdata;
					iend_q <= mem_rdata.start + mem_rdata.size;
					j_q <= '0;
					if (mem_rdata.size == 64'd0) begin
						i_q <= i_q + CW'(1);
						state_q <= S_P1_I_RD;
					end else begin
						state_q <= S_P1_J_RD;
					end
				end
				S_P1_J_RD: begin
					if (j_q >= cnt_q) begin
						state_q <= S_P1_I_WR;
					end else if (j_q == i_q) begin
						j_q <= j_q + CW'(1);
					end else begin
						state_q <= S_P1_J_LD;
					end
				end
				S_P1_J_LD: begin
					je_q <= mem_rdata;
					jend_q <= mem_rdata.start + mem_rdata.size;
					if (mem_rdata.size == 64'd0) begin
						j_q <= j_q + CW'(1);
						state_q <= S_P1_J_RD;
					end else begin
						state_q <= S_P1_J_EX;
					end
				end
				S_P1_J_EX: begin
					if (p1_cont && (je_q.kind > ie_q.kind)) begin
						if (({1'b0, cnt_q} + (CW + 1)'(1)) >= LIM_W) begin
							status_q <= mrme_pkg::ST_FULL;
							state_q <= S_P1_ABORT;
						end else begin
							state_q <= S_P1_SPLIT;
						end
					end else begin
						if (!p1_cont && p1_part && (je_q.kind > ie_q.kind)) begin
							ie_q.size <= je_q.start - ie_q.start;
							iend_q <= je_q.start;
						end
						j_q <= j_q + CW'(1);
						state_q <= S_P1_J_RD;
					end
				end
				S_P1_SPLIT: begin
					cnt_q <= cnt_q + CW'(1);
					ie_q.size <= je_q.start - ie_q.start;
					iend_q <= je_q.start;
					j_q <= j_q + CW'(1);
					state_q <= S_P1_J_RD;
				end
				S_P1_I_WR: begin
					i_q <= i_q + CW'(1);
					state_q <= S_P1_I_RD;
				end
				S_P1_ABORT: state_q <= S_FIN;
				S_P2_I_RD: begin
					if (i_q >= cnt_q) begin
						i_q <= '0;
						j_q <= '0;
						state_q <= S_CP_RD;
					end else begin
						state_q <= S_P2_I_LD;
					end
				end
				S_P2_I_LD: begin
					ie_q <= mem_rdata;
					j_q <= '0;
					if (mem_rdata.size == 64'd0) begin
						i_q <= i_q + CW'(1);
						state_q <= S_P2_I_RD;
					end else begin
						state_q <= S_P2_J_RD;
					end
				end
				S_P2_J_RD: begin
					if (j_q >= cnt_q) begin
						state_q <= S_P2_I_WR;
					end else if (j_q == i_q) begin
						j_q <= j_q + CW'(1);
					end else begin
						state_q <= S_P2_J_LD;
					end
				end
				S_P2_J_LD: begin
					je_q <= mem_rdata;
					jend_q <= mem_rdata.start + mem_rdata.size;
					if (mem_rdata.size == 64'd0) begin
						j_q <= j_q + CW'(1);
						state_q <= S_P2_J_RD;
					end else begin
						state_q <= S_P2_J_EX;
					end
				end
				S_P2_J_EX: begin
					if (p2_merge) begin
						ie_q.size <= 64'd0;
					end
					j_q <= j_q + CW'(1);
					state_q <= S_P2_J_RD;
				end
				S_P2_I_WR: begin
					i_q <= i_q + CW'(1);
					state_q <= S_P2_I_RD;
				end
				S_CP_RD: begin
					if (i_q >= cnt_q) begin
						cnt_q <= j_q;
						i_q <= '0;
						state_q <= S_AL_RD;
					end else begin
						state_q <= S_CP_LD;
					end
				end
				S_CP_LD: begin
					if (mem_rdata.size != 64'd0) begin
						j_q <= j_q + CW'(1);
					end
					i_q <= i_q + CW'(1);
					state_q <= S_CP_RD;
				end
				S_AL_RD: begin
					if (i_q >= cnt_q) begin
						i_q <= '0;
						state_q <= S_SO_I;
					end else begin
						state_q <= S_AL_LD;
					end
				end
				S_AL_LD: begin
					je_q <= mem_rdata;
					if (al_hit) begin
						state_q <= S_AL_EX;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_AL_RD;
					end
				end
				S_AL_EX: begin
					if (al_rem != 64'd0) begin
						je_q.start <= je_q.start + (PSIZE - al_rem);
						je_q.size <= je_q.size - (PSIZE - al_rem);
					end
					state_q <= S_AL_WR;
				end
				S_AL_WR: begin
					i_q <= i_q + CW'(1);
					state_q <= S_AL_RD;
				end
				S_SO_I: begin
					if (i_q >= cnt_q) begin
						status_q <= mrme_pkg::ST_OK;
						if (req_q) begin
							granted_q <= cl_base_q[31:0];
						end
						state_q <= S_FIN;
					end else begin
						least_q <= i_q;
						j_q <= i_q;
						state_q <= S_SO_J_RD;
					end
				end
				S_SO_J_RD: begin
					if (j_q >= cnt_q) begin
						if (least_q != i_q) begin
							state_q <= S_SO_SW1;
						end else begin
							i_q <= i_q + CW'(1);
							state_q <= S_SO_I;
						end
					end else begin
						state_q <= S_SO_J_LD;
					end
				end
				S_SO_J_LD: begin
					if (j_q == i_q) begin
						ie_q <= mem_rdata;
						le_q <= mem_rdata;
					end else if (le_q.start > mem_rdata.start) begin
						le_q <= mem_rdata;
						least_q <= j_q;
					end
					j_q <= j_q + CW'(1);
					state_q <= S_SO_J_RD;
				end
				S_SO_SW1: state_q <= S_SO_SW2;
				S_SO_SW2: begin
					i_q <= i_q + CW'(1);
					state_q <= S_SO_I;
				end
				S_CL_START: begin
					i_q <= '0;
					cl_end_q <= cl_base_q + cl_len_q;
					if (({1'b0, cnt_q} + (CW + 1)'(1)) >= LIM_W) begin
						status_q <= mrme_pkg::ST_FULL;
						state_q <= S_FIN;
					end else if (((cl_base_q & PMASK) != 64'd0) ||
					             ((cl_len_q & PMASK) != 64'd0)) begin
						if (req_q) begin
							k_q <= k_q + CW'(1);
							state_q <= S_RQ_RD;
						end else begin
							status_q <= mrme_pkg::ST_REFUSED;
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_CL_RD;
					end
				end
				S_CL_RD: begin
					state_q <= (i_q >= cnt_q) ? S_CL_APP : S_CL_LD;
				end
				S_CL_LD: begin
					je_q <= mem_rdata;
					jend_q <= mem_rdata.start + mem_rdata.size;
					state_q <= S_CL_EX;
				end
				S_CL_EX: begin
					if (jend_q <= cl_base_q) begin
						i_q <= i_q + CW'(1);
						state_q <= S_CL_RD;
					end else if (je_q.start >= cl_end_q) begin
						state_q <= S_CL_APP;
					end else if (je_q.kind > kind_q) begin
						if (req_q) begin
							k_q <= k_q + CW'(1);
							state_q <= S_RQ_RD;
						end else begin
							status_q <= mrme_pkg::ST_REFUSED;
							state_q <= S_FIN;
						end
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_CL_RD;
					end
				end
				S_CL_APP: begin
					cnt_q <= cnt_q + CW'(1);
					i_q <= '0;
					state_q <= S_P1_I_RD;
				end
				S_RQ_RD: begin
					state_q <= (k_q >= cnt_q) ? S_FIN : S_RQ_LD;
				end
				S_RQ_LD: begin
					if ((mem_rdata.kind == usable_q) && (mem_rdata.size >= size_q) &&
					    (mem_rdata.start < mrme_pkg::ADDR32_MAX)) begin
						cl_base_q <= mem_rdata.start;
						cl_len_q <= size_q;
						state_q <= S_CL_START;
					end else begin
						k_q <= k_q + CW'(1);
						state_q <= S_RQ_RD;
					end
				end
				S_FIN: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q <= {1'b0, tot32[8:0], rde_q.kind, rde_q.size, rde_q.start,
							granted_q, status_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/mrme_checker.sv =====
// Region table predictor and result checker for the memory region map engine.
module mrme_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [mrme_pkg::IN_BITS-1:0]  s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [mrme_pkg::OUT_BITS-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	output int                            fail_count,
	output int                            outstanding,
	output int                            entries
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted;
		logic [63:0] base;
		logic [63:0] length;
		logic [3:0]  kind;
		logic [8:0]  total;
	} reply_t;

	localparam int LIMIT = mrme_pkg::MAX_REGIONS_DEF - 1;
	localparam logic [63:0] PAGE = 64'(mrme_pkg::PAGE_BYTES_DEF);

	logic [63:0] rstart [mrme_pkg::MAX_REGIONS_DEF];
	logic [63:0] rsize  [mrme_pkg::MAX_REGIONS_DEF];
	logic [3:0]  rkind  [mrme_pkg::MAX_REGIONS_DEF];
	int          rcount;
	logic [3:0]  usable_kind;
	logic [3:0]  reclaim_kind;
	reply_t      replies_due [$];

	function automatic void move_region(int dst, int src);
		rstart[dst] = rstart[src];
		rsize[dst]  = rsize[src];
		rkind[dst]  = rkind[src];
	endfunction

	function automatic bit tidy_table();
		int i, j, n, least;
		logic [63:0] iend, jend, r, ts, tl;
		logic [3:0] tk;
		for (i = 0; i < rcount; i++) begin
			if (rsize[i] == 0) continue;
			iend = rstart[i] + rsize[i];
			for (j = 0; j < rcount; j++) begin
				if (i == j || rsize[j] == 0) continue;
				jend = rstart[j] + rsize[j];
				if (rstart[j] >= rstart[i] && jend <= iend) begin
					if (rkind[j] <= rkind[i]) begin
						rsize[j] = 0;
					end else begin
						n = rcount;
						if (n + 1 >= LIMIT) return 0;
						rkind[n]  = rkind[i];
						rstart[n] = jend;
						rsize[n]  = iend - jend;
						rcount    = n + 1;
						rsize[i]  = rstart[j] - rstart[i];
						iend      = rstart[i] + rsize[i];
					end
					continue;
				end
				if (rstart[j] >= rstart[i] && rstart[j] < iend) begin
					if (rkind[j] > rkind[i]) begin
						rsize[i] = rstart[j] - rstart[i];
						iend = rstart[i] + rsize[i];
					end
					if (rkind[j] < rkind[i]) begin
						rsize[j]  = rsize[j] - (iend - rstart[j]);
						rstart[j] = iend;
					end
				end
			end
		end
		for (i = 0; i < rcount; i++) begin
			if (rsize[i] == 0) continue;
			for (j = 0; j < rcount; j++) begin
				if (i == j || rsize[j] == 0) continue;
				if (rstart[j] + rsize[j] != rstart[i]) continue;
				if (rkind[j] != rkind[i]) continue;
				rsize[j] = rsize[j] + rsize[i];
				rsize[i] = 0;
			end
		end
		j = 0;
		for (i = 0; i < rcount; i++) begin
			if (rsize[i] == 0) continue;
			if (j != i) move_region(j, i);
			j++;
		end
		rcount = j;
		for (i = 0; i < rcount; i++) begin
			if (rkind[i] != usable_kind && rkind[i] != reclaim_kind) continue;
			r = rstart[i] % PAGE;
			if (r != 0) begin
				rstart[i] = rstart[i] + (PAGE - r);
				rsize[i]  = rsize[i] - (PAGE - r);
			end
			rsize[i] = rsize[i] - (rsize[i] % PAGE);
		end
		for (i = 0; i < rcount; i++) begin
			least = i;
			for (j = i; j < rcount; j++)
				if (rstart[least] > rstart[j]) least = j;
			if (least != i) begin
				ts = rstart[i]; tl = rsize[i]; tk = rkind[i];
				move_region(i, least);
				rstart[least] = ts; rsize[least] = tl; rkind[least] = tk;
			end
		end
		return 1;
	endfunction

	function automatic logic [1:0] claim_range(logic [63:0] b, logic [63:0] len,
		logic [3:0] k);
		logic [63:0] e;
		int i;
		if (rcount + 1 >= LIMIT) return mrme_pkg::ST_FULL;
		if (b % PAGE != 0 || len % PAGE != 0) return mrme_pkg::ST_REFUSED;
		e = b + len;
		for (i = 0; i < rcount; i++) begin
			if (rstart[i] + rsize[i] <= b) continue;
			if (rstart[i] >= e) break;
			if (rkind[i] > k) return mrme_pkg::ST_REFUSED;
		end
		rstart[rcount] = b;
		rsize[rcount]  = len;
		rkind[rcount]  = k;
		rcount++;
		return tidy_table() ? mrme_pkg::ST_OK : mrme_pkg::ST_FULL;
	endfunction

	function automatic reply_t run_command(logic [mrme_pkg::IN_BITS-1:0] d);
		reply_t rp;
		logic [2:0]  cmd;
		logic [63:0] b, len, sz;
		logic [3:0]  k;
		logic [51:0] pages;
		logic [7:0]  idx;
		logic [1:0]  r;
		int i;
		cmd = d[2:0]; b = d[66:3]; len = d[130:67]; k = d[134:131];
		pages = d[186:135]; idx = d[194:187];
		rp = '0;
		case (cmd)
			mrme_pkg::CMD_APPEND: begin
				if (rcount >= LIMIT) begin
					rp.status = mrme_pkg::ST_FULL;
				end else if (!(b < mrme_pkg::LOW_BOUND && len <= mrme_pkg::LOW_BOUND)) begin
					if (b < mrme_pkg::LOW_BOUND) begin
						len = len - (mrme_pkg::LOW_BOUND - b);
						b = mrme_pkg::LOW_BOUND;
					end
					rstart[rcount] = b; rsize[rcount] = len; rkind[rcount] = k;
					rcount++;
				end
			end
			mrme_pkg::CMD_SANITIZE: begin
				if (!tidy_table()) rp.status = mrme_pkg::ST_FULL;
			end
			mrme_pkg::CMD_CLAIM: rp.status = claim_range(b, len, k);
			mrme_pkg::CMD_REQUEST: begin
				sz = {pages, 12'h000};
				rp.status = mrme_pkg::ST_NOFIT;
				for (i = 0; i < rcount; i++) begin
					b = rstart[i];
					if (rkind[i] != usable_kind) continue;
					if (rsize[i] < sz) continue;
					if (b >= mrme_pkg::ADDR32_MAX) continue;
					r = claim_range(b, sz, k);
					if (r == mrme_pkg::ST_REFUSED) continue;
					rp.status = r;
					if (r == mrme_pkg::ST_OK) rp.granted = b[31:0];
					break;
				end
			end
			mrme_pkg::CMD_READ: begin
				if (idx < rcount) begin
					rp.base = rstart[idx]; rp.length = rsize[idx]; rp.kind = rkind[idx];
				end
			end
			default: ;
		endcase
		rp.total = 9'(rcount);
		return rp;
	endfunction

	always @(posedge clk) begin
		reply_t want, got;
		if (!arst_n) begin
			rcount = 0;
			usable_kind = 4'd1;
			reclaim_kind = 4'd6;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[1:0], m_tdata[33:2], m_tdata[97:34], m_tdata[161:98],
					m_tdata[165:162], m_tdata[174:166]};
				if (replies_due.size() == 0) begin
					$display("%t unexpected result beat %h", $time, got);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status || got.granted !== want.granted ||
						got.base !== want.base || got.length !== want.length ||
						got.kind !== want.kind || got.total !== want.total) begin
						$display("%t mismatch status exp %0d got %0d granted exp %h got %h",
							$time, want.status, got.status, want.granted, got.granted);
						$display("  base exp %h got %h length exp %h got %h", want.base,
							got.base, want.length, got.length);
						$display("  kind exp %0d got %0d total exp %0d got %0d", want.kind,
							got.kind, want.total, got.total);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(run_command(s_tdata));
			if (psel && penable && pwrite && pready) begin
				if (paddr == 3'd0) usable_kind = pwdata[3:0];
				else if (paddr == 3'd4) reclaim_kind = pwdata[3:0];
			end
		end
		outstanding = replies_due.size();
		entries = rcount;
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for the memory region map engine testbench.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk = 0;
	logic                          arst_n;
	logic                          s_tvalid, s_tready;
	logic [mrme_pkg::IN_BITS-1:0]  s_tdata;
	logic                          m_tvalid, m_tready;
	logic [mrme_pkg::OUT_BITS-1:0] m_tdata;
	logic                          psel, penable, pwrite, pready;
	logic [2:0]                    paddr;
	logic [31:0]                   pwdata, prdata;
	int                            fail_count, outstanding, entries;
	int                            rx_beats = 0;
	bit                            rx_held = 0;

	localparam logic [63:0] KB4 = 64'h1000;

	memory_region_map_engine DUT (.*);

	mrme_checker u_checker (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		int r;
		if (arst_n) begin
			if (m_tvalid && m_tready) rx_beats++;
			r = $urandom_range(0, 99);
			if (rx_beats >= 30 && !rx_held) begin
				rx_held = 1;
				m_tready <= 0;
				repeat (400) @(posedge clk);
			end else if (rx_beats > 60 && rx_beats < 80) begin
				m_tready <= 1;
			end else if (r < 70) begin
				m_tready <= 1;
			end else if (r < 97) begin
				m_tready <= 0;
			end else begin
				m_tready <= 0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	task automatic issue(logic [2:0] cmd, logic [63:0] b, logic [63:0] len,
		logic [3:0] k, logic [51:0] pages, logic [7:0] idx);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {5'b0, idx, pages, k, len, b, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] a, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] pick_addr();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return {$urandom, $urandom};
		if (r < 3) return KB4 * $urandom_range(0, 64) + $urandom_range(1, 4095);
		return KB4 * $urandom_range(0, 64);
	endfunction

	function automatic logic [63:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return {$urandom, $urandom};
		if (r < 3) return KB4 * $urandom_range(0, 16) + $urandom_range(1, 4095);
		return KB4 * $urandom_range(0, 16);
	endfunction

	task automatic random_items(int n, logic [3:0] fav);
		int r;
		logic [2:0] cmd;
		logic [3:0] k;
		logic [51:0] pages;
		repeat (n) begin
			r = $urandom_range(0, 99);
			cmd = r < 30 ? mrme_pkg::CMD_APPEND : r < 45 ? mrme_pkg::CMD_SANITIZE :
				r < 65 ? mrme_pkg::CMD_CLAIM : r < 80 ? mrme_pkg::CMD_REQUEST :
				r < 95 ? mrme_pkg::CMD_READ : 3'($urandom_range(5, 7));
			if (entries >= 24 && (cmd == mrme_pkg::CMD_APPEND ||
				cmd == mrme_pkg::CMD_CLAIM || cmd == mrme_pkg::CMD_REQUEST))
				cmd = mrme_pkg::CMD_READ;
			k = ($urandom_range(0, 2) == 0) ? fav : 4'($urandom);
			pages = ($urandom_range(0, 9) == 0) ? {20'($urandom), $urandom} :
				52'($urandom_range(0, 4));
			issue(cmd, pick_addr(), pick_len(), k, pages, 8'($urandom));
		end
	endtask

	initial begin
		int fill;
		arst_n = 0;
		s_tvalid <= 0; s_tdata <= '0; m_tready <= 0;
		psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(3'd0, 32'd1);
		write_reg(3'd4, 32'd6);

		issue(mrme_pkg::CMD_APPEND, 64'h0, 64'h1000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h800, 64'h3000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h10000, 64'h10000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h12000, 64'h2000, 4'd5, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h1f000, 64'h4000, 4'd3, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h30800, 64'h2800, 4'd6, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h33000, 64'h1000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h34000, 64'h1000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_SANITIZE, 64'h0, 64'h0, 4'd0, 52'd0, 8'd0);
		for (int i = 0; i < 6; i++)
			issue(mrme_pkg::CMD_READ, 64'h0, 64'h0, 4'd0, 52'd0, 8'(i));
		issue(mrme_pkg::CMD_READ, 64'h0, 64'h0, 4'd0, 52'd0, 8'hff);
		issue(mrme_pkg::CMD_CLAIM, 64'h40800, 64'h1000, 4'd2, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_CLAIM, 64'h12000, 64'h1000, 4'd0, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_CLAIM, 64'h14000, 64'h2000, 4'd4, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_REQUEST, 64'h0, 64'h0, 4'd2, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_REQUEST, 64'h0, 64'h0, 4'd7, 52'd2, 8'd0);
		issue(mrme_pkg::CMD_REQUEST, 64'h0, 64'h0, 4'd7, '1, 8'd0);
		issue(3'd7, '1, '1, 4'hf, '1, 8'hff);
		issue(mrme_pkg::CMD_APPEND, '1, '1, 4'hf, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_SANITIZE, 64'h0, 64'h0, 4'd0, 52'd0, 8'd0);
		random_items(30, 4'd1);

		drain();
		write_reg(3'd0, 32'd0);
		write_reg(3'd4, 32'd15);
		random_items(35, 4'd0);

		drain();
		write_reg(3'd0, 32'd15);
		write_reg(3'd4, 32'd0);
		random_items(35, 4'd15);

		drain();
		write_reg(3'd0, 32'd1);
		write_reg(3'd4, 32'd6);
		fill = 253 - entries - 2;
		issue(mrme_pkg::CMD_APPEND, 64'h10_0000_0000, 64'h10_0000, 4'd14, 52'd0, 8'd0);
		for (int i = 0; i < fill; i++)
			issue(mrme_pkg::CMD_APPEND, 64'h20_0000_0000 + 64'(i) * 64'h2000, 64'h1000,
				4'd14, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h10_0000_8000, 64'h1000, 4'd15, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_SANITIZE, 64'h0, 64'h0, 4'd0, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h30_0000_0000, 64'h1000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_APPEND, 64'h31_0000_0000, 64'h1000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_CLAIM, 64'h40_0000_0000, 64'h1000, 4'd1, 52'd0, 8'd0);
		issue(mrme_pkg::CMD_REQUEST, 64'h0, 64'h0, 4'd1, 52'd1, 8'd0);
		issue(mrme_pkg::CMD_READ, 64'h0, 64'h0, 4'd0, 52'd0, 8'd254);
		issue(mrme_pkg::CMD_READ, 64'h0, 64'h0, 4'd0, 52'd0, 8'd255);

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
